// ===== hdl/sliding_window_min_max_top_defines.svh =====
// Assertion macros for the sliding window min/max block.
// No dependencies; taken in by the top level through `include.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_DEFINES_SVH

`ifndef SYNTH
// property must hold at every edge outside reset
`define SWMM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("swmm check failed");
// condition must never be seen outside reset
`define SWMM_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("swmm forbidden condition");
`else
`define SWMM_ASSERT(label, prop)
`define SWMM_NEVER(label, cond)
`endif

`endif

// ===== hdl/swmm_pkg.sv =====
// Shared types and constants for the sliding window min/max block.
// No dependencies.
`default_nettype none

package swmm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int WLEN_W   = 7;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd3;

   // running extremes handed from cell to cell
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
   } swmm_part_type;

endpackage

`default_nettype wire

// ===== hdl/swmm_cell.sv =====
// One window slot: holds one sample of the history and folds it into the
// running min/max coming from the older neighbour. Uses swmm_pkg.
`default_nettype none

module swmm_cell import swmm_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       shift_en,
   input  wire logic signed [SAMPLE_W-1:0] sample_in,
   output      logic signed [SAMPLE_W-1:0] sample_out,
   input  wire logic                       chain_en,
   input  wire swmm_part_type              part_in,
   output      swmm_part_type              part_out
);

   logic signed [SAMPLE_W-1:0] sample_ff;
   swmm_part_type              part_ff;
   swmm_part_type              part_in_c;

   always_comb begin
      part_in_c.lo = sample_ff;
      part_in_c.hi = sample_ff;
      if (chain_en) begin
         if (part_in.lo < sample_ff) part_in_c.lo = part_in.lo;
         if (part_in.hi > sample_ff) part_in_c.hi = part_in.hi;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
      part_ff <= part_in_c;
   end

   assign sample_out = sample_ff;
   assign part_out   = part_ff;

endmodule

`default_nettype wire

// ===== hdl/sliding_window_min_max_top.sv =====
// Top level of the sliding window min/max block: controller, config
// register and the row of swmm_cell slots. Uses swmm_pkg and the defines.
`default_nettype none
`include "sliding_window_min_max_top_defines.svh"

// Channel   Ports                      Word contents (lowest bit up)
// req       req_tvalid/tready/tdata    tdata[31:0] sample, tlast end_of_sequence
// rsp       rsp_tvalid/tready/tdata    tdata[31:0] window_min, [63:32] window_max,
//                                      tlast sequence_done
// csr       csr_valid/ready/data       data[6:0] window_len, always ready
//
// Sequence: a word that completes no window leaves the controller idle; one that
//   completes a window is shifted into the cell row at the accept edge, then
//   min/max ripple from the oldest slot to slot 0 while the sweep count runs
//   down from k (k = effective length), and then the output register is loaded.
// Reset: synchronous; clears fill count, controller and rsp valid; window_len 3.
// Stalls: a held rsp word delays the load of the next result; req stays not ready until that load.

module sliding_window_min_max_top import swmm_pkg::*; #(
   parameter int MAX_WINDOW = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // req_tdata: [31:0] sample
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [SAMPLE_W-1:0] req_tdata,
   input  wire logic                req_tlast,
   // rsp_tdata: [31:0] window_min, [63:32] window_max
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [2*SAMPLE_W-1:0] rsp_tdata,
   output      logic                rsp_tlast,
   // csr_data: [6:0] window_len
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [WLEN_W-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WINDOW);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_SWEEP = 1'b1;

   logic                  state_ff, state_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [WLEN_W-1:0]     wlen_ff;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2*SAMPLE_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic [CW-1:0]         k_eff;
   logic [CW-1:0]         fill_next;
   logic                  req_acc;
   logic                  rsp_load;

   logic signed [SAMPLE_W-1:0] sample_chain [MAX_WINDOW+1];
   swmm_part_type              part_chain   [MAX_WINDOW+1];

   // effective window: zero counts as one, clamp to the row length
   always_comb begin
      if (wlen_ff == '0) begin
         k_eff = CW'(1);
      end else if (32'(wlen_ff) > 32'(MAX_WINDOW)) begin
         k_eff = MAX_CNT;
      end else begin
         k_eff = CW'(wlen_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign fill_next  = (fill_ff == MAX_CNT) ? fill_ff : fill_ff + 1'b1;
   assign rsp_load   = (state_ff == ST_SWEEP) && (cnt_ff == '0) &&
                       (!rsp_valid_ff || rsp_tready);

   // controller
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               fill_in = req_tlast ? '0 : fill_next;
               if (fill_next >= k_eff) begin
                  state_in = ST_SWEEP;
                  cnt_in   = k_eff;
                  last_in  = req_tlast;
               end
            end
         end
         ST_SWEEP: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end else if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wlen_ff      <= WLEN_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            wlen_ff <= csr_data;
         end
      end
   end

   // output register, payload only
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {part_chain[0].hi, part_chain[0].lo};
         rsp_last_ff <= last_ff;
      end
   end

   // cell row: slot 0 holds the newest sample; extremes ripple towards slot 0
   assign sample_chain[0]          = $signed(req_tdata);
   assign part_chain[MAX_WINDOW]   = '0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic chain_en;
      assign chain_en = (32'(i) + 32'd1) < 32'(k_eff);

      swmm_cell u_cell (
         .clock      (clock),
         .shift_en   (req_acc),
         .sample_in  (sample_chain[i]),
         .sample_out (sample_chain[i+1]),
         .chain_en   (chain_en),
         .part_in    (part_chain[i+1]),
         .part_out   (part_chain[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

   // checks
   `SWMM_ASSERT(a_rsp_from_sweep, $rose(rsp_tvalid) |-> $past(state_ff == ST_SWEEP))
   `SWMM_NEVER(a_fill_range, fill_ff > MAX_CNT)
   `SWMM_ASSERT(a_idle_cnt_clear, (state_ff == ST_IDLE) |-> (cnt_ff == '0))

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for sliding_window_min_max_top: streams sample words,
// predicts each window's min/max/done and checks every rsp word in order.
// Depends on swmm_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
   import swmm_pkg::*;

   localparam int MAX_WINDOW = 64;
   // latency of the slowest word: full window ripple plus load, with margin
   localparam int SETTLE_CYCLES = MAX_WINDOW + 8;
   // cycles with no word moving on any channel before the run is abandoned
   localparam int STALL_LIMIT = 3000;

   localparam logic signed [SAMPLE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
      logic                       done;
   } window_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata  = '0;   // [31:0] sample
   logic                  req_tlast  = 1'b0; // end_of_sequence
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [2*SAMPLE_W-1:0] rsp_tdata;         // [31:0] window_min, [63:32] window_max
   logic                  rsp_tlast;         // sequence_done
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [WLEN_W-1:0]     csr_data   = '0;   // [6:0] window_len

   // shadow of the block: register, samples of the open sequence, pending windows
   logic [WLEN_W-1:0]          window_len_shadow = WLEN_RESET;
   logic signed [SAMPLE_W-1:0] open_sequence [$];
   window_result_type          window_results [$];

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int errors          = 0;
   int items_sent      = 0;
   int windows_checked = 0;
   int lengths_written = 0;
   int quiet_cycles    = 0;

   sliding_window_min_max_top #(
      .MAX_WINDOW (MAX_WINDOW)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // --------------------------------------------------------------------
   // Window predictor
   // --------------------------------------------------------------------

   // zero behaves as one, anything past the cell row as the full row
   function automatic int effective_span(input logic [WLEN_W-1:0] len);
      if (len == 0)
         return 1;
      if (len > MAX_WINDOW)
         return MAX_WINDOW;
      return int'(len);
   endfunction

   function automatic void predict_window(input logic signed [SAMPLE_W-1:0] value,
                                          input logic eos);
      int span;
      int i;
      window_result_type r;
      logic signed [SAMPLE_W-1:0] v;
      span = effective_span(window_len_shadow);
      // queue length doubles as the fill count, saturating at the row size
      open_sequence.push_back(value);
      if (open_sequence.size() > MAX_WINDOW)
         void'(open_sequence.pop_front());
      if (open_sequence.size() >= span) begin
         r.lo   = value;
         r.hi   = value;
         r.done = eos;
         for (i = 1; i < span; i++) begin
            v = open_sequence[open_sequence.size() - 1 - i];
            if (v < r.lo)
               r.lo = v;
            if (v > r.hi)
               r.hi = v;
         end
         window_results.push_back(r);
      end
      if (eos)
         open_sequence.delete();
   endfunction

   // --------------------------------------------------------------------
   // Shared drivers. All driving happens at the rising edge; handshakes are
   // sampled at the falling edge, where every signal has settled. Each task
   // starts and ends on a rising edge.
   // --------------------------------------------------------------------

   function automatic void set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            sender_idle_pct = 61;
            recv_stall_pct  = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            recv_stall_pct  = 61;
         end
         IDLE_BOTH: begin
            sender_idle_pct = 37;
            recv_stall_pct  = 37;
         end
         default: begin
            sender_idle_pct = 0;
            recv_stall_pct  = 0;
         end
      endcase
   endfunction

   // valid is left high after the accept so that back-to-back words need no
   // second assignment in the same step; release_req drops it
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic eos);
      logic taken;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= eos;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      predict_window(value, eos);
      items_sent++;
   endtask

   task automatic release_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // register writes only with the block idle: no sample word offered, all
   // windows back, and time for any word still in the row to finish
   task automatic write_window_len(input logic [WLEN_W-1:0] len);
      logic taken;
      release_req();
      while (window_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      window_len_shadow = len;
      lengths_written++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return MOST_NEGATIVE;
         1:       return MOST_POSITIVE;
         2, 3:    return $signed(32'($urandom_range(15))) - 8; // near zero, many ties
         4:       return MOST_NEGATIVE + $urandom_range(3);
         5:       return MOST_POSITIVE - $urandom_range(3);
         default: return $signed($urandom());
      endcase
   endfunction

   // --------------------------------------------------------------------
   // Receiver: random back-pressure and in-order check of each rsp word
   // --------------------------------------------------------------------

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(negedge clock) begin
      window_result_type want;
      logic signed [SAMPLE_W-1:0] got_lo;
      logic signed [SAMPLE_W-1:0] got_hi;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_lo = $signed(rsp_tdata[SAMPLE_W-1:0]);
         got_hi = $signed(rsp_tdata[2*SAMPLE_W-1:SAMPLE_W]);
         if (window_results.size() == 0) begin
            errors++;
            $display("%0t window: expected none, got min %0d max %0d done %0b",
                     $time, got_lo, got_hi, rsp_tlast);
         end else begin
            want = window_results.pop_front();
            windows_checked++;
            if (got_lo !== want.lo) begin
               errors++;
               $display("%0t window_min: expected %0d, got %0d", $time, want.lo, got_lo);
            end
            if (got_hi !== want.hi) begin
               errors++;
               $display("%0t window_max: expected %0d, got %0d", $time, want.hi, got_hi);
            end
            if (rsp_tlast !== want.done) begin
               errors++;
               $display("%0t sequence_done: expected %0b, got %0b",
                        $time, want.done, rsp_tlast);
            end
         end
      end
   end

   // watchdog: a run of cycles in which no word moves on any channel
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // length 3 from reset: field extremes, a closing window and a short sequence
   task automatic test_reset_window();
      set_idling(IDLE_NONE);
      send_sample(MOST_NEGATIVE, 1'b0);
      send_sample(MOST_POSITIVE, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd1, 1'b1);
      // ends before a window fills: no result, count restarts
      send_sample(32'sd5, 1'b0);
      send_sample(32'sd6, 1'b1);
   endtask

   // zero acts as one, above the row as the full row
   task automatic test_length_clamp();
      write_window_len('0);
      send_sample(MOST_POSITIVE, 1'b1);
      send_sample(MOST_NEGATIVE, 1'b0);
      send_sample(32'sd42, 1'b1);
      write_window_len(7'd1);
      send_sample(-32'sd7, 1'b1);
      write_window_len(7'd127);
      send_sample(32'sd3, 1'b0);
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd1, 1'b1);
   endtask

   // new length takes effect on the next word, against samples already held
   task automatic test_midsequence_change();
      write_window_len(7'd2);
      send_sample(32'sd10, 1'b0);
      send_sample(32'sd20, 1'b0);
      send_sample(32'sd30, 1'b0);
      write_window_len(7'd5);
      send_sample(32'sd40, 1'b0);
      send_sample(-32'sd50, 1'b1);
   endtask

   // random sequences over a spread of lengths and idling patterns; phases
   // end wherever the budget runs out, so sequences straddle length changes
   task automatic test_random_streams();
      logic [WLEN_W-1:0] lens [0:11];
      int p;
      int budget;
      int span;
      int seq_len;
      int i;
      lens = '{7'd2, 7'd4, 7'd1, 7'd7, 7'd64, 7'd3,
               7'd16, 7'd127, 7'd5, 7'd0, 7'd65, 7'd8};
      for (p = 0; p < 12; p++) begin
         write_window_len(lens[p]);
         set_idling(idle_mode_type'(p % 4));
         budget = 95;
         while (budget > 0) begin
            span = effective_span(window_len_shadow);
            if ($urandom_range(4) == 0)
               seq_len = $urandom_range(span, 1);
            else
               seq_len = $urandom_range(3 * span, span);
            for (i = 0; i < seq_len && budget > 0; i++) begin
               send_sample(pick_sample(), i == seq_len - 1);
               budget--;
            end
         end
      end
   endtask

   task automatic test_drain();
      set_idling(IDLE_NONE);
      release_req();
      while (window_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_length_clamp();
      test_midsequence_change();
      test_random_streams();
      test_drain();
      $display("%0d sample words sent, %0d windows checked, %0d length writes",
               items_sent, windows_checked, lengths_written);
      $display("lengths 0 to 127 incl. clamped values, four idling patterns, %0d errors",
               errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
